@@ rtl/settable_clock_counter_defines.svh @@
// Assertion macros for the checker file of the clock counter.
// No dependencies; included by scc_checker.sv.
`ifndef SETTABLE_CLOCK_COUNTER_DEFINES_SVH
`define SETTABLE_CLOCK_COUNTER_DEFINES_SVH

// Checked only while out of reset.
`define SCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define SCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/scc_pkg.sv @@
// Package for the settable clock counter: constants, payload types, helpers.
// No dependencies; imported by scc_rate, scc_core, scc_obuf and the top level.
package scc_pkg;

    localparam logic [5:0]  SEC_LIMIT  = 6'd60;
    localparam logic [5:0]  MIN_LIMIT  = 6'd60;
    localparam logic [5:0]  HOUR_LIMIT = 6'd24;
    localparam logic [5:0]  HOUR_WRAP  = 6'd24;
    localparam logic [15:0] TPS_RESET  = 16'd1000;
    localparam int          PADDR_W    = 2;
    localparam logic        REG_TPS    = 1'b0;   // word index of ticks_per_second
    localparam logic        MODE_TICK  = 1'b0;
    localparam logic        MODE_BTN   = 1'b1;

    typedef struct packed {
        logic [1:0] pad;
        logic       view_is_min_sec;
        logic       dot_on;
        logic [5:0] right_pair;
        logic [5:0] left_pair;
    } res_t;

    typedef struct packed {
        logic        load;
        logic [15:0] rem_full;
        logic [15:0] rem_half;
    } rem_load_t;

    function automatic logic [5:0] step_field(input logic [5:0] v, input logic up,
                                              input logic down, input logic [5:0] lim);
        logic [5:0] t;
        t = (up && (v < lim)) ? v + 6'd1 : v;
        if (down && (t != 6'd0)) begin
            t = t - 6'd1;
        end
        return t;
    endfunction

endpackage

@@ rtl/scc_rate.sv @@
// Rate register with APB access, and a shift-subtract unit that recomputes
// the tick counter's remainders after ticks_per_second is written. Uses scc_pkg.
module scc_rate (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    input  logic [15:0]                 tick_count,
    output logic [15:0]                 tps,
    output logic                        busy,
    output scc_pkg::rem_load_t          rem_ld
);
    import scc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic        state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] tps_reg, tps_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [15:0] rf_reg, rf_next;
    logic [15:0] rh_reg, rh_next;
    logic [15:0] half;
    logic [16:0] rf_sh, rh_sh, rf_sub, rh_sub;
    logic [15:0] rf_step, rh_step;
    logic        wr;

    assign wr   = psel && penable && pwrite && (paddr[1] == REG_TPS);
    assign half = {1'b0, tps_reg[15:1]};

    assign rf_sh   = {rf_reg, dvd_reg[15]};
    assign rh_sh   = {rh_reg, dvd_reg[15]};
    assign rf_sub  = rf_sh - {1'b0, tps_reg};
    assign rh_sub  = rh_sh - {1'b0, half};
    assign rf_step = (rf_sh >= {1'b0, tps_reg}) ? rf_sub[15:0] : rf_sh[15:0];
    assign rh_step = (rh_sh >= {1'b0, half}) ? rh_sub[15:0] : rh_sh[15:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tps_next   = tps_reg;
        dvd_next   = dvd_reg;
        rf_next    = rf_reg;
        rh_next    = rh_reg;
        rem_ld     = '0;
        if (wr) begin
            tps_next   = pwdata[15:0];
            state_next = ST_RUN;
            cnt_next   = 4'd0;
            dvd_next   = tick_count;
            rf_next    = 16'd0;
            rh_next    = 16'd0;
        end else begin
            case (state_reg)
                ST_RUN: begin
                    dvd_next = {dvd_reg[14:0], 1'b0};
                    rf_next  = rf_step;
                    rh_next  = rh_step;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_next      = ST_IDLE;
                        rem_ld.load     = 1'b1;
                        rem_ld.rem_full = (tps_reg == 16'd0) ? 16'd0 : rf_step;
                        rem_ld.rem_half = (half == 16'd0) ? 16'd0 : rh_step;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
            tps_reg   <= TPS_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tps_reg   <= tps_next;
        end
        dvd_reg <= dvd_next;
        rf_reg  <= rf_next;
        rh_reg  <= rh_next;
    end

    assign tps    = tps_reg;
    assign busy   = (state_reg == ST_RUN);
    assign prdata = (paddr[1] == REG_TPS) ? {16'd0, tps_reg} : 32'd0;

endmodule

@@ rtl/scc_core.sv @@
// Time-of-day state: tick counter with remainders, dot, h/m/s and view,
// updated by one tick or button item per cycle. Uses scc_pkg.
module scc_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               mode,
    input  logic [3:0]         btn,        // a_up, a_down, b_up, b_down from bit 0
    input  logic [15:0]        tps,
    input  scc_pkg::rem_load_t rem_ld,
    output logic [15:0]        tick_count,
    output scc_pkg::res_t      res
);
    import scc_pkg::*;

    logic [15:0] tick_reg, tick_next;
    logic [15:0] rf_reg, rf_next;
    logic [15:0] rh_reg, rh_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic        view_reg, view_next;
    logic        dot_reg, dot_next;

    logic [15:0] tick_inc, rf_inc, rh_inc, half;
    logic        wrap, half_hit, full_hit, view_t;
    logic [5:0]  sec_t, min_t, hour_t, hour_b;

    assign half     = {1'b0, tps[15:1]};
    assign tick_inc = tick_reg + 16'd1;
    assign rf_inc   = rf_reg + 16'd1;
    assign rh_inc   = rh_reg + 16'd1;
    assign wrap     = (tick_inc == 16'd0);
    assign half_hit = (half != 16'd0) && !wrap && (rh_inc == half);
    assign full_hit = (tps != 16'd0) && !wrap && (rf_inc == tps);
    assign view_t   = (&btn) ? ~view_reg : view_reg;

    always_comb begin
        tick_next = tick_reg;
        rf_next   = rf_reg;
        rh_next   = rh_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        view_next = view_reg;
        dot_next  = dot_reg;
        sec_t     = sec_reg;
        min_t     = min_reg;
        hour_t    = {1'b0, hour_reg};
        hour_b    = {1'b0, hour_reg};
        if (rem_ld.load) begin
            rf_next = rem_ld.rem_full;
            rh_next = rem_ld.rem_half;
        end else if (in_fire && (mode == MODE_TICK)) begin
            dot_next = dot_reg ^ half_hit;
            if (full_hit) begin
                tick_next = 16'd0;
                rf_next   = 16'd0;
                rh_next   = 16'd0;
                sec_t     = sec_reg + 6'd1;
            end else begin
                tick_next = tick_inc;
                rf_next   = (wrap || (tps == 16'd0)) ? 16'd0 : rf_inc;
                rh_next   = (wrap || (half == 16'd0) || half_hit) ? 16'd0 : rh_inc;
            end
            if (sec_t >= SEC_LIMIT) begin
                min_t = min_t + 6'd1;
                sec_t = 6'd0;
            end
            if (min_t >= MIN_LIMIT) begin
                hour_t = hour_t + 6'd1;
                min_t  = 6'd0;
            end
            if (hour_t >= HOUR_WRAP) begin
                hour_t = 6'd0;
            end
            sec_next  = sec_t;
            min_next  = min_t;
            hour_next = hour_t[4:0];
        end else if (in_fire && (mode == MODE_BTN) && (|btn)) begin
            view_next = view_t;
            if (view_t) begin
                sec_next = step_field(sec_reg, btn[0], btn[1], SEC_LIMIT);
                min_next = step_field(min_reg, btn[2], btn[3], MIN_LIMIT);
            end else begin
                min_next  = step_field(min_reg, btn[0], btn[1], MIN_LIMIT);
                hour_b    = step_field({1'b0, hour_reg}, btn[2], btn[3], HOUR_LIMIT);
                hour_next = hour_b[4:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= 16'd0;
            rf_reg   <= 16'd0;
            rh_reg   <= 16'd0;
            sec_reg  <= 6'd0;
            min_reg  <= 6'd0;
            hour_reg <= 5'd0;
            view_reg <= 1'b1;
            dot_reg  <= 1'b0;
        end else begin
            tick_reg <= tick_next;
            rf_reg   <= rf_next;
            rh_reg   <= rh_next;
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            view_reg <= view_next;
            dot_reg  <= dot_next;
        end
    end

    always_comb begin
        res                 = '0;
        res.view_is_min_sec = view_next;
        res.dot_on          = dot_next;
        res.left_pair       = view_next ? min_next : {1'b0, hour_next};
        res.right_pair      = view_next ? sec_next : min_next;
    end

    assign tick_count = tick_reg;

endmodule

@@ rtl/scc_obuf.sv @@
// Two-entry result buffer (output register plus skid entry) for the
// result channel. Uses scc_pkg.
module scc_obuf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  scc_pkg::res_t push_data,
    output logic          full,
    output logic          m_tvalid,
    input  logic          m_tready,
    output scc_pkg::res_t m_data
);
    import scc_pkg::*;

    logic v0_reg, v0_next, v1_reg, v1_next;
    res_t d0_reg, d0_next, d1_reg, d1_next;
    logic pop;

    assign pop = v0_reg && m_tready;

    always_comb begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (pop) begin
            if (v1_reg) begin
                d0_next = d1_reg;
                v1_next = push;
                d1_next = push_data;
            end else begin
                v0_next = push;
                d0_next = push_data;
            end
        end else if (push) begin
            if (!v0_reg) begin
                v0_next = 1'b1;
                d0_next = push_data;
            end else begin
                v1_next = 1'b1;
                d1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign full     = v1_reg;
    assign m_tvalid = v0_reg;
    assign m_data   = d0_reg;

endmodule

@@ rtl/settable_clock_counter.sv @@
// Settable time-of-day clock. An accepted item's result is registered, in the
// output register or in the skid entry. Throughput: one item per cycle while
// s_tready is high; the two-entry result buffer lets one more item in while a
// result waits. After a ticks_per_second write, the shift-subtract unit holds
// s_tready low while it recomputes the remainders. Reset: synchronous, active
// low; clock 00:00:00, m:s view, dot off, ticks_per_second 1000, result buffer empty.
module settable_clock_counter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // a_up, a_down, b_up, b_down, pad
    input  logic                        s_tuser,   // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // left_pair, right_pair, dot_on, pad
    output logic                        m_tuser,   // view_is_min_sec
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import scc_pkg::*;

    logic      busy, full, in_fire;
    logic [15:0] tps, tick_count;
    rem_load_t rem_ld;
    res_t      res, m_data;

    assign pready   = 1'b1;
    assign s_tready = !busy && !full;
    assign in_fire  = s_tvalid && s_tready;

    scc_rate u_rate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .tick_count (tick_count),
        .tps        (tps),
        .busy       (busy),
        .rem_ld     (rem_ld)
    );

    scc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .mode       (s_tuser),
        .btn        (s_tdata[3:0]),
        .tps        (tps),
        .rem_ld     (rem_ld),
        .tick_count (tick_count),
        .res        (res)
    );

    scc_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (res),
        .full      (full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (m_data)
    );

    assign m_tdata = {3'b000, m_data.dot_on, m_data.right_pair, m_data.left_pair};
    assign m_tuser = m_data.view_is_min_sec;

endmodule

@@ rtl/scc_checker.sv @@
// Port-level checks for settable_clock_counter, bound to the top level.
// Depends on settable_clock_counter_defines.svh.
module scc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [1:0]  paddr
);
`include "settable_clock_counter_defines.svh"

    logic        in_fire;
    logic        out_stall;
    logic        tps_write;
    logic        pairs_ok;
    logic [16:0] m_word;

    assign in_fire   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign tps_write = psel && penable && pwrite && !paddr[1];
    assign pairs_ok  = (m_tdata[5:0] <= 6'd60) && (m_tdata[11:6] <= 6'd60);
    assign m_word    = {m_tuser, m_tdata};

    `SCC_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result after reset")
    `SCC_ASSERT(a_item_result, aclk, aresetn, in_fire |=> m_tvalid, "item lost")
    `SCC_ASSERT(a_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(m_word), "stalled item")
    `SCC_ASSERT(a_pair_range, aclk, aresetn, m_tvalid |-> pairs_ok, "pair out of range")
    `SCC_ASSERT(a_cfg_busy, aclk, aresetn, tps_write |=> !s_tready, "item during rate update")

endmodule

bind settable_clock_counter scc_checker u_scc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr)
);
